### hdl/assert_macros.svh
// Assertion macros for the depth pixel to world point block.
// Needs clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge, off while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/dpwp_pkg.sv
// Package for the depth pixel to world point block: image geometry,
// register indexes and the reciprocal table for the sampling stride test.
package dpwp_pkg;

  localparam int IMG_WIDTH   = 640;
  localparam int IMG_HEIGHT  = 480;
  localparam int EDGE_MARGIN = 0;

  localparam int CFG_W  = 32;
  localparam int CFGI_W = 3;

  localparam logic [CFGI_W-1:0] REG_FOCAL_X_RECIP = 3'd0;
  localparam logic [CFGI_W-1:0] REG_FOCAL_Y_RECIP = 3'd1;
  localparam logic [CFGI_W-1:0] REG_CENTER_X      = 3'd2;
  localparam logic [CFGI_W-1:0] REG_CENTER_Y      = 3'd3;
  localparam logic [CFGI_W-1:0] REG_DEPTH_SCALE   = 3'd4;
  localparam logic [CFGI_W-1:0] REG_MAX_DEPTH     = 3'd5;
  localparam logic [CFGI_W-1:0] REG_MIN_DEPTH     = 3'd6;
  localparam logic [CFGI_W-1:0] REG_PIXEL_SKIP    = 3'd7;

  localparam logic REQ_POSE  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  // ceil(2^16 / d); q = (n * recip) >> 16 equals n / d for n < 2^10
  typedef logic [16:0] recip_t;
  localparam recip_t SKIP_RECIP [32] = '{
    17'd65536, 17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108, 17'd10923,
    17'd9363,  17'd8192,  17'd7282,  17'd6554,  17'd5958,  17'd5462,  17'd5042,
    17'd4682,  17'd4370,  17'd4096,  17'd3856,  17'd3641,  17'd3450,  17'd3277,
    17'd3121,  17'd2979,  17'd2850,  17'd2731,  17'd2622,  17'd2521,  17'd2428,
    17'd2341,  17'd2260,  17'd2185,  17'd2115
  };

endpackage

### hdl/depth_pixel_to_world_point_unit.sv
// Top level of the depth pixel to world point block: an eight stage pipeline
// from raw depth pixel to world point. Uses dpwp_pkg and assert_macros.svh.
//
//  channel | dir | handshake         | content
//  s_      | in  | tvalid/tready     | pose or depth pixel item, kind in tuser
//  m_      | out | tvalid/tready     | world point item
//  cfg_    | in  | we, no wait       | register index and data
//
// Eight register stages; one item per cycle while the output register is not stalled.
// All stages move together; a stalled output register holds every stage.
// A pose item updates the rotation and position on leaving stage five, so
// pixels before it use the old pose and pixels after it the new one.
// Reset is synchronous: it clears the valid bits, loads the config defaults and sets an identity pose at the origin.
`include "assert_macros.svh"

module depth_pixel_to_world_point_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // quat_w, quat_x, quat_y, quat_z, cam_pos_x, cam_pos_y, cam_pos_z,
  // pixel_col, pixel_row, depth_raw, zero pad
  input  logic [199:0]                     s_tdata,
  // req_type
  input  logic [0:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // world_x, world_y, world_z
  output logic [95:0]                      m_tdata,
  input  logic                             cfg_we,
  input  logic [dpwp_pkg::CFGI_W-1:0]      cfg_index,
  input  logic [dpwp_pkg::CFG_W-1:0]       cfg_data
);
  import dpwp_pkg::*;

  // configuration
  logic [31:0] focal_x_recip, focal_y_recip, depth_scale_recip, max_depth, min_depth;
  logic [25:0] center_x;
  logic [24:0] center_y;
  logic [4:0]  pixel_skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x_recip     <= 32'd10737418;
      focal_y_recip     <= 32'd10737418;
      center_x          <= 26'd20971520;
      center_y          <= 25'd15728640;
      depth_scale_recip <= 32'd4294967;
      max_depth         <= 32'd327680;
      min_depth         <= 32'd6554;
      pixel_skip        <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOCAL_X_RECIP: focal_x_recip     <= cfg_data;
        REG_FOCAL_Y_RECIP: focal_y_recip     <= cfg_data;
        REG_CENTER_X:      center_x          <= cfg_data[25:0];
        REG_CENTER_Y:      center_y          <= cfg_data[24:0];
        REG_DEPTH_SCALE:   depth_scale_recip <= cfg_data;
        REG_MAX_DEPTH:     max_depth         <= cfg_data;
        REG_MIN_DEPTH:     min_depth         <= cfg_data;
        REG_PIXEL_SKIP:    pixel_skip        <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [4:0] skip_eff;
  assign skip_eff = (pixel_skip == 5'd0) ? 5'd1 : pixel_skip;

  // input fields
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] in_pos [3];
  logic [9:0]  col;
  logic [8:0]  row;
  logic [15:0] raw;
  assign qw        = s_tdata[15:0];
  assign qx        = s_tdata[31:16];
  assign qy        = s_tdata[47:32];
  assign qz        = s_tdata[63:48];
  assign in_pos[0] = s_tdata[95:64];
  assign in_pos[1] = s_tdata[127:96];
  assign in_pos[2] = s_tdata[159:128];
  assign col       = s_tdata[169:160];
  assign row       = s_tdata[178:170];
  assign raw       = s_tdata[194:179];

  logic adv;
  logic v1, v2, v3, v4, v5, v6, v7, v8;
  logic pose1, pose2, pose3, pose4, pose5;

  assign adv      = !v8 || m_tready;
  assign s_tready = adv && !rst;

  // pose state
  logic signed [15:0] rot [9];
  logic signed [31:0] pos [3];
  logic signed [15:0] r3 [9], r4 [9], r5 [9];
  logic signed [31:0] p1 [3], p2 [3], p3 [3], p4 [3], p5 [3];

  // stage 1: depth scaling, stride quotients, centred coordinates, quaternion products
  logic [47:0] raw_prod1;
  logic        raw_zero1, in_margin1;
  logic [9:0]  colm1;
  logic [8:0]  rowm1;
  logic [26:0] qc_prod1;
  logic [25:0] qr_prod1;
  logic signed [26:0] ax1, ay1;
  logic signed [31:0] pq1 [9]; // xx yy zz xy xz yz wx wy wz
  logic        in_margin;

  assign in_margin = (32'(col) >= EDGE_MARGIN) && (32'(col) < IMG_WIDTH - EDGE_MARGIN) &&
                     (32'(row) >= EDGE_MARGIN) && (32'(row) < IMG_HEIGHT - EDGE_MARGIN);

  always_ff @(posedge clk) begin
    if (adv) begin
      raw_prod1  <= 48'(raw) * 48'(depth_scale_recip);
      raw_zero1  <= (raw == 16'd0);
      in_margin1 <= in_margin;
      colm1      <= col - 10'(EDGE_MARGIN);
      rowm1      <= row - 9'(EDGE_MARGIN);
      qc_prod1   <= 27'(col - 10'(EDGE_MARGIN)) * 27'(SKIP_RECIP[skip_eff]);
      qr_prod1   <= 26'(row - 9'(EDGE_MARGIN)) * 26'(SKIP_RECIP[skip_eff]);
      ax1        <= $signed({1'b0, col, 16'b0}) - $signed({1'b0, center_x});
      ay1        <= $signed({2'b0, row, 16'b0}) - $signed({2'b0, center_y});
      pq1[0]     <= qx * qx;
      pq1[1]     <= qy * qy;
      pq1[2]     <= qz * qz;
      pq1[3]     <= qx * qy;
      pq1[4]     <= qx * qz;
      pq1[5]     <= qy * qz;
      pq1[6]     <= qw * qx;
      pq1[7]     <= qw * qy;
      pq1[8]     <= qw * qz;
      p1         <= in_pos;
    end
  end

  // stage 2: clamp and filter depth, grid test, normalised coordinate products, quaternion sums
  logic [48:0] dsum;
  logic [31:0] depth_r, depth_next;
  logic        far, near, on_col, on_row, keep;
  logic [15:0] qcs;
  logic [14:0] qrs;
  logic [31:0] depth2;
  logic signed [59:0] px2, py2;
  logic signed [32:0] s2 [9];

  assign dsum       = {1'b0, raw_prod1} + 49'h0_8000_0000;
  assign depth_r    = {15'b0, dsum[48:32]};
  assign far        = raw_zero1 || (depth_r > max_depth);
  assign depth_next = far ? max_depth : depth_r;
  assign near       = !far && (depth_r < min_depth);
  assign qcs        = 16'(qc_prod1[26:16]) * 16'(skip_eff);
  assign qrs        = 15'(qr_prod1[25:16]) * 15'(skip_eff);
  assign on_col     = (qcs == {6'b0, colm1});
  assign on_row     = (qrs == {6'b0, rowm1});
  assign keep       = in_margin1 && on_col && on_row && !near;

  always_ff @(posedge clk) begin
    if (adv) begin
      depth2 <= depth_next;
      px2    <= ax1 * $signed({1'b0, focal_x_recip});
      py2    <= ay1 * $signed({1'b0, focal_y_recip});
      s2[0]  <= 33'(pq1[1]) + 33'(pq1[2]);
      s2[1]  <= 33'(pq1[3]) - 33'(pq1[8]);
      s2[2]  <= 33'(pq1[4]) + 33'(pq1[7]);
      s2[3]  <= 33'(pq1[3]) + 33'(pq1[8]);
      s2[4]  <= 33'(pq1[0]) + 33'(pq1[2]);
      s2[5]  <= 33'(pq1[5]) - 33'(pq1[6]);
      s2[6]  <= 33'(pq1[4]) - 33'(pq1[7]);
      s2[7]  <= 33'(pq1[5]) + 33'(pq1[6]);
      s2[8]  <= 33'(pq1[0]) + 33'(pq1[1]);
      p2     <= p1;
    end
  end

  // stage 3: round the normalised coordinates, round and saturate matrix entries
  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    if (v > 21'sd32767)       return 16'sd32767;
    else if (v < -21'sd32768) return -16'sd32768;
    else                      return v[15:0];
  endfunction

  logic signed [59:0] nxs, nys;
  logic signed [27:0] nx3, ny3;
  logic [31:0] depth3;
  logic signed [33:0] rs [9];
  logic signed [15:0] r_next [9];

  assign nxs = px2 + 60'sh8000_0000;
  assign nys = py2 + 60'sh8000_0000;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rs[i] = (34'(s2[i]) + 34'sd4096) >>> 13;
      if (i == 0 || i == 4 || i == 8)
        r_next[i] = sat16(21'(ONE_Q14) - 21'(rs[i]));
      else
        r_next[i] = sat16(21'(rs[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx3    <= nxs[59:32];
      ny3    <= nys[59:32];
      depth3 <= depth2;
      r3     <= r_next;
      p3     <= p2;
    end
  end

  // stage 4: camera frame products
  logic signed [60:0] cx4, cy4;
  logic [31:0] depth4;

  always_ff @(posedge clk) begin
    if (adv) begin
      cx4    <= nx3 * $signed({1'b0, depth3});
      cy4    <= ny3 * $signed({1'b0, depth3});
      depth4 <= depth3;
      r4     <= r3;
      p4     <= p3;
    end
  end

  // stage 5: round camera frame point
  logic signed [60:0] cxs, cys;
  logic signed [44:0] cam5 [3];

  assign cxs = cx4 + 61'sh8000;
  assign cys = cy4 + 61'sh8000;

  always_ff @(posedge clk) begin
    if (adv) begin
      cam5[0] <= cxs[60:16];
      cam5[1] <= cys[60:16];
      cam5[2] <= $signed({13'b0, depth4});
      r5      <= r4;
      p5      <= p4;
    end
  end

  // pose commit as the pose item leaves stage 5
  logic pose_commit;
  assign pose_commit = adv && v5 && (pose5 == REQ_POSE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++)
        rot[i] <= (i % 4 == 0) ? ONE_Q14 : 16'sd0;
      for (int i = 0; i < 3; i++)
        pos[i] <= 32'sd0;
    end else if (pose_commit) begin
      rot <= r5;
      pos <= p5;
    end
  end

  // stage 6: rotation products, position snapshot
  logic signed [60:0] m6 [9];
  logic signed [31:0] p6 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++)
        m6[i] <= rot[i] * cam5[i % 3];
      p6 <= pos;
    end
  end

  // stage 7: row sums
  logic signed [62:0] sum7 [3];
  logic signed [31:0] p7 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        sum7[i] <= 63'(m6[3*i]) + 63'(m6[3*i+1]) + 63'(m6[3*i+2]);
      p7 <= p6;
    end
  end

  // stage 8: round, translate, saturate into the output register
  logic signed [62:0] rsum [3];
  logic signed [49:0] wv [3];
  logic signed [31:0] w_next [3];
  logic signed [31:0] world [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = sum7[i] + 63'sd8192;
      wv[i]   = 50'($signed(rsum[i][62:14])) + 50'(p7[i]);
      if (wv[i] > 50'sd2147483647)        w_next[i] = 32'sh7FFF_FFFF;
      else if (wv[i] < -50'sd2147483648)  w_next[i] = 32'sh8000_0000;
      else                                w_next[i] = wv[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv)
      world <= w_next;
  end

  // valid bits and item kind; dropped pixels and poses leave as bubbles
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
      {pose1, pose2, pose3, pose4, pose5} <= '0;
    end else if (adv) begin
      v1    <= s_tvalid;
      pose1 <= s_tuser[0];
      v2    <= v1 && ((pose1 == REQ_POSE) || keep);
      pose2 <= pose1;
      v3    <= v2;
      pose3 <= pose2;
      v4    <= v3;
      pose4 <= pose3;
      v5    <= v4;
      pose5 <= pose4;
      v6    <= v5 && (pose5 == REQ_PIXEL);
      v7    <= v6;
      v8    <= v7;
    end
  end

  assign m_tvalid = v8;
  assign m_tdata  = {world[2], world[1], world[0]};

  `ASSERT_CLK(a_stall_holds, !adv |=> (v1 == $past(v1)) && (v5 == $past(v5)) && (v7 == $past(v7)), "pipeline moved while stalled")
  `ASSERT_CLK(a_out_follows, adv && v7 |=> m_tvalid, "stage 7 item lost before output")
  `ASSERT_CLK(a_pose_commit, pose_commit |=> (rot[0] == $past(r5[0])) && (pos[2] == $past(p5[2])), "pose not committed")
  `ASSERT_ALWAYS(a_reset_clear, $past(rst) |-> !m_tvalid, "output valid after reset")

endmodule
